@@ rtl/core/blr_pkg.sv @@
package blr_pkg;

  // Command codes carried by the input beat.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Fixed field widths.
  localparam int CFG_BITS   = 13;
  localparam int COLOR_BITS = 8;
  localparam int ADDR_BITS  = 24;

  // Frame dimensions after reset.
  localparam int DEFAULT_DIM = 512;

endpackage

@@ rtl/core/blr_front.sv @@
module blr_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic signed [COORD_BITS-1:0]          in_start_x,
  input  logic signed [COORD_BITS-1:0]          in_start_y,
  input  logic signed [COORD_BITS-1:0]          in_end_x,
  input  logic signed [COORD_BITS-1:0]          in_end_y,
  input  logic [blr_pkg::COLOR_BITS-1:0]        in_pen_color,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [2*COORD_BITS+blr_pkg::COLOR_BITS:0] q_data
);
  import blr_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int D_W = C + 2;
  localparam int E_W = C + 3;
  localparam int T_W = C + 4;

  logic signed [C-1:0]   cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [D_W-1:0] adx_r, nady_r;
  logic signed [E_W-1:0] err_r;
  logic                  sxn_r, syn_r, active_r;
  logic [COLOR_BITS-1:0] color_r;

  logic                  accept, is_load, emit;
  logic signed [C:0]     dx_w, dy_w, adx_abs, nady_abs;
  logic signed [D_W-1:0] adx_ld, nady_ld;
  logic signed [E_W-1:0] err_ld, add_x, add_y, err_adv;
  logic signed [T_W-1:0] dbl;
  logic                  go_x, go_y;
  logic signed [C-1:0]   step_x, step_y, cx_adv, cy_adv, pt_x, pt_y;
  logic                  last_ld, last_adv, pt_last;
  logic [COLOR_BITS-1:0] pt_color;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_load  = (in_command == CMD_LOAD);
  assign emit     = accept && (is_load || active_r);

  // Segment setup on a load.
  assign dx_w     = (C+1)'(in_end_x) - (C+1)'(in_start_x);
  assign dy_w     = (C+1)'(in_end_y) - (C+1)'(in_start_y);
  assign adx_abs  = dx_w[C] ? -dx_w : dx_w;
  assign nady_abs = dy_w[C] ? dy_w : -dy_w;
  assign adx_ld   = D_W'(adx_abs);
  assign nady_ld  = D_W'(nady_abs);
  assign err_ld   = E_W'(adx_ld) + E_W'(nady_ld);
  assign last_ld  = (in_start_x == in_end_x) && (in_start_y == in_end_y);

  // One Bresenham step on an advance.
  assign dbl      = $signed({err_r, 1'b0});
  assign go_x     = dbl >= T_W'(nady_r);
  assign go_y     = dbl <= T_W'(adx_r);
  assign add_x    = go_x ? E_W'(nady_r) : E_W'(0);
  assign add_y    = go_y ? E_W'(adx_r) : E_W'(0);
  assign err_adv  = err_r + add_x + add_y;
  assign step_x   = sxn_r ? -C'(1) : C'(1);
  assign step_y   = syn_r ? -C'(1) : C'(1);
  assign cx_adv   = go_x ? cur_x_r + step_x : cur_x_r;
  assign cy_adv   = go_y ? cur_y_r + step_y : cur_y_r;
  assign last_adv = (cx_adv == tgt_x_r) && (cy_adv == tgt_y_r);

  assign pt_x     = is_load ? in_start_x : cx_adv;
  assign pt_y     = is_load ? in_start_y : cy_adv;
  assign pt_color = is_load ? in_pen_color : color_r;
  assign pt_last  = is_load ? last_ld : last_adv;

  assign q_push = emit;
  assign q_data = {pt_x, pt_y, pt_color, pt_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      adx_r    <= '0;
      nady_r   <= '0;
      err_r    <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (emit) begin
      if (is_load) begin
        cur_x_r <= in_start_x;
        cur_y_r <= in_start_y;
        tgt_x_r <= in_end_x;
        tgt_y_r <= in_end_y;
        adx_r   <= adx_ld;
        nady_r  <= nady_ld;
        err_r   <= err_ld;
        sxn_r   <= !(in_start_x < in_end_x);
        syn_r   <= !(in_start_y < in_end_y);
        color_r <= in_pen_color;
      end else begin
        cur_x_r <= cx_adv;
        cur_y_r <= cy_adv;
        err_r   <= err_adv;
      end
      active_r <= !pt_last;
    end
  end

endmodule

@@ rtl/core/blr_queue.sv @@
module blr_queue #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head,
  output logic             full
);

  // Two slots; slot 0 is always the head.
  logic [WIDTH-1:0] slot0_r, slot1_r, slot0_nxt, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_pop;

  assign head_valid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign head       = slot0_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r + 2'(push) - 2'(do_pop);
    if (do_pop) begin
      if (cnt_r == 2'd2) begin
        slot0_nxt = slot1_r;
        if (push) begin
          slot1_nxt = din;
        end
      end else if (push) begin
        slot0_nxt = din;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = din;
      end else begin
        slot1_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

@@ rtl/core/blr_back.sv @@
module blr_back #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 13
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      head_valid,
  input  logic [2*COORD_BITS+blr_pkg::COLOR_BITS:0] head,
  output logic                                      pop,
  input  logic [DIM_BITS-1:0]                       frame_w,
  input  logic [DIM_BITS-1:0]                       frame_h,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [COORD_BITS-1:0]              out_point_x,
  output logic signed [COORD_BITS-1:0]              out_point_y,
  output logic [blr_pkg::ADDR_BITS-1:0]             out_pixel_address,
  output logic [blr_pkg::COLOR_BITS-1:0]            out_pixel_color,
  output logic                                      out_write_enable,
  output logic                                      out_last_point
);
  import blr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int XW = (C > DIM_BITS) ? C : DIM_BITS;
  localparam int PW = ((2 * DIM_BITS > ADDR_BITS) ? 2 * DIM_BITS : ADDR_BITS) + 1;

  logic [C-1:0]          x_q, y_q;
  logic [COLOR_BITS-1:0] color_q;
  logic                  last_q;
  logic [XW-1:0]         x_u, y_u;
  logic                  on_screen;
  logic [PW-1:0]         addr_sum;

  logic                  valid_r;
  logic [C-1:0]          x_r, y_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  we_r, last_r;

  assign {x_q, y_q, color_q, last_q} = head;

  // Output register refills whenever it is empty or being drained.
  assign pop = head_valid && (!valid_r || !out_stall);

  assign x_u       = XW'(x_q);
  assign y_u       = XW'(y_q);
  assign on_screen = !x_q[C-1] && !y_q[C-1] &&
                     (x_u < XW'(frame_w)) && (y_u < XW'(frame_h));
  assign addr_sum  = PW'(y_u[DIM_BITS-1:0]) * PW'(frame_w) + PW'(x_u[DIM_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (pop) begin
      x_r     <= x_q;
      y_r     <= y_q;
      color_r <= color_q;
      last_r  <= last_q;
      we_r    <= on_screen;
      addr_r  <= on_screen ? addr_sum[ADDR_BITS-1:0] : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_point_x       = $signed(x_r);
  assign out_point_y       = $signed(y_r);
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_write_enable  = we_r;
  assign out_last_point    = last_r;

endmodule

@@ rtl/core/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer: one point per load, or per advance while a line is active.
// Each point is registered in a queue slot and then in the back end's output
// register, which presents it as the result beat.
// Throughput: one beat per cycle unless the queue is full; the step is combinational.
// Reset (rst_n low, synchronous) idles the line, empties the queue and output
// register, and sets frame width and height to 512 (clamped to MAX_FRAME_DIM).
module bresenham_line_rasterizer #(
  parameter int COORD_BITS    = 16,
  parameter int MAX_FRAME_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [blr_pkg::CFG_BITS-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [COORD_BITS-1:0]        in_start_x,
  input  logic signed [COORD_BITS-1:0]        in_start_y,
  input  logic signed [COORD_BITS-1:0]        in_end_x,
  input  logic signed [COORD_BITS-1:0]        in_end_y,
  input  logic [blr_pkg::COLOR_BITS-1:0]      in_pen_color,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        out_point_x,
  output logic signed [COORD_BITS-1:0]        out_point_y,
  output logic [blr_pkg::ADDR_BITS-1:0]       out_pixel_address,
  output logic [blr_pkg::COLOR_BITS-1:0]      out_pixel_color,
  output logic                                out_write_enable,
  output logic                                out_last_point
);
  import blr_pkg::*;

  // The design splits into a front end that takes beats, decodes the
  // command and runs the Bresenham stepper, a two-entry queue of points,
  // and a back end that clips each point against the frame, forms the
  // linear address with one multiply-add and holds the result beat.
  // The front end stalls only when the queue is full, so a stalled output
  // does not stop input until both queue slots are taken.

  localparam int DIM_BITS  = $clog2(MAX_FRAME_DIM + 1);
  localparam int CMP_W     = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;
  localparam int RESET_DIM = (DEFAULT_DIM > MAX_FRAME_DIM) ? MAX_FRAME_DIM : DEFAULT_DIM;
  localparam int Q_W       = 2 * COORD_BITS + COLOR_BITS + 1;

  logic [DIM_BITS-1:0] frame_w_r, frame_h_r;
  logic [CMP_W-1:0]    wr_ext, wr_clamped;

  logic           q_push, q_pop, q_full, q_head_valid;
  logic [Q_W-1:0] q_din, q_head;

  // Writes are clamped to the largest supported frame dimension on the way
  // in, so the back end only ever sees in-range sizes.
  assign wr_ext     = CMP_W'(cfg_wr_data);
  assign wr_clamped = (wr_ext > CMP_W'(MAX_FRAME_DIM)) ? CMP_W'(MAX_FRAME_DIM) : wr_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= DIM_BITS'(RESET_DIM);
      frame_h_r <= DIM_BITS'(RESET_DIM);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_w_r <= wr_clamped[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: frame_h_r <= wr_clamped[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_pen_color (in_pen_color),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_din)
  );

  blr_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .din        (q_din),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .full       (q_full)
  );

  blr_back #(
    .COORD_BITS(COORD_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head              (q_head),
    .pop               (q_pop),
    .frame_w           (frame_w_r),
    .frame_h           (frame_h_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_write_enable  (out_write_enable),
    .out_last_point    (out_last_point)
  );

endmodule

@@ rtl/core/blr_checker.sv @@
module blr_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [COORD_BITS-1:0]         out_point_x,
  input logic [COORD_BITS-1:0]         out_point_y,
  input logic [blr_pkg::ADDR_BITS-1:0] out_pixel_address,
  input logic                          out_write_enable
);
  import blr_pkg::*;

  // A held result beat keeps its point and its address.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) &&
    $stable(out_point_y) && $stable(out_pixel_address))
    else $error("result beat changed while stalled");

  // Off-screen points carry a zero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel_address == '0)
    else $error("off-screen point with nonzero address");

  // Enabled writes never have negative coordinates.
  a_we_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> !out_point_x[COORD_BITS-1] &&
    !out_point_y[COORD_BITS-1])
    else $error("write enabled for negative coordinate");

  // Reset leaves no result beat and an open input.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind bresenham_line_rasterizer blr_checker #(
  .COORD_BITS(COORD_BITS)
) u_blr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_point_x       (out_point_x),
  .out_point_y       (out_point_y),
  .out_pixel_address (out_pixel_address),
  .out_write_enable  (out_write_enable)
);
